// ===== rtl/core/rdq_pkg.sv =====
// ----------------------------------------------------------------------------
// rdq_pkg
// Shared codes, widths and control types for the restricted deque unit.
// ----------------------------------------------------------------------------
package rdq_pkg;

    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int DATA_W   = 32;

    localparam int S_TDATA_W = 40;  // cmd + push_value, padded to bytes
    localparam int M_TDATA_W = 40;  // status + pop_value + flags, padded

    localparam logic [CMD_W-1:0] CMD_INS_REAR  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DEL_REAR  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY     = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOSPACE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FORBIDDEN = 2'd3;

    localparam logic MODE_IN_RESTRICTED  = 1'b0;
    localparam logic MODE_OUT_RESTRICTED = 1'b1;

    typedef struct packed {
        logic load;     // capture the incoming request
        logic exec;     // apply the request and register its result
    } rdq_ctrl_t;

endpackage

// ===== rtl/core/rdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// rdq_ctrl
// Sequencer: takes a request, runs it through the datapath, holds the result.
// ----------------------------------------------------------------------------
module rdq_ctrl
    import rdq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output rdq_ctrl_t ctrl
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = (state_reg == ST_OUT);
    assign ctrl.load = (state_reg == ST_IDLE) && s_tvalid;
    assign ctrl.exec = (state_reg == ST_EXEC);

endmodule

// ===== rtl/core/rdq_datapath.sv =====
// ----------------------------------------------------------------------------
// rdq_datapath
// Slot memory, head/tail indices, mode register and result registers.
// ----------------------------------------------------------------------------
module rdq_datapath
    import rdq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  rdq_ctrl_t           ctrl,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [DATA_W-1:0]   push_value,
    output logic [STATUS_W-1:0] status,
    output logic [DATA_W-1:0]   pop_value,
    output logic                is_empty,
    output logic                is_full
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [IDX_W-1:0] ZERO_IDX = '0;

    logic [DATA_W-1:0] slot_mem [DEPTH];

    logic                mode_reg;
    logic [CMD_W-1:0]    cmd_reg;
    logic [DATA_W-1:0]   val_reg;
    logic [IDX_W-1:0]    head_reg;
    logic [IDX_W-1:0]    head_next;
    logic [IDX_W-1:0]    tail_reg;
    logic [IDX_W-1:0]    tail_next;
    logic                empty_reg;
    logic                empty_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic                pop_ok_reg;
    logic                pop_ok_next;
    logic                is_empty_reg;
    logic                is_full_reg;
    logic [DATA_W-1:0]   rd_data_reg;

    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [IDX_W-1:0]    mem_raddr;

    always_comb
    begin
        head_next   = head_reg;
        tail_next   = tail_reg;
        empty_next  = empty_reg;
        status_next = ST_OK;
        pop_ok_next = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = tail_reg;
        mem_raddr   = head_reg;
        case (cmd_reg)
            CMD_INS_REAR:
            begin
                if (empty_reg)
                begin
                    head_next  = ZERO_IDX;
                    tail_next  = ZERO_IDX;
                    empty_next = 1'b0;
                    mem_we     = 1'b1;
                    mem_waddr  = ZERO_IDX;
                end
                else if (tail_reg == LAST_IDX)
                begin
                    status_next = ST_NOSPACE;
                end
                else
                begin
                    tail_next = tail_reg + 1'b1;
                    mem_we    = 1'b1;
                    mem_waddr = tail_reg + 1'b1;
                end
            end
            CMD_INS_FRONT:
            begin
                if (mode_reg != MODE_OUT_RESTRICTED)
                begin
                    status_next = ST_FORBIDDEN;
                end
                else if (empty_reg)
                begin
                    head_next  = ZERO_IDX;
                    tail_next  = ZERO_IDX;
                    empty_next = 1'b0;
                    mem_we     = 1'b1;
                    mem_waddr  = ZERO_IDX;
                end
                else if (head_reg == ZERO_IDX)
                begin
                    status_next = ST_NOSPACE;
                end
                else
                begin
                    head_next = head_reg - 1'b1;
                    mem_we    = 1'b1;
                    mem_waddr = head_reg - 1'b1;
                end
            end
            CMD_DEL_FRONT:
            begin
                mem_raddr = head_reg;
                if (empty_reg)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    pop_ok_next = 1'b1;
                    if (head_reg >= tail_reg)
                    begin
                        head_next  = ZERO_IDX;
                        tail_next  = ZERO_IDX;
                        empty_next = 1'b1;
                    end
                    else
                    begin
                        head_next = head_reg + 1'b1;
                    end
                end
            end
            CMD_DEL_REAR:
            begin
                mem_raddr = tail_reg;
                if (mode_reg != MODE_IN_RESTRICTED)
                begin
                    status_next = ST_FORBIDDEN;
                end
                else if (empty_reg)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    pop_ok_next = 1'b1;
                    if (tail_reg <= head_reg)
                    begin
                        head_next  = ZERO_IDX;
                        tail_next  = ZERO_IDX;
                        empty_next = 1'b1;
                    end
                    else
                    begin
                        tail_next = tail_reg - 1'b1;
                    end
                end
            end
            CMD_QUERY:
            begin
                status_next = ST_OK;
            end
            default:
            begin
                status_next = ST_FORBIDDEN;
            end
        endcase
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (ctrl.exec && mem_we)
        begin
            slot_mem[mem_waddr] <= val_reg;
        end
        if (ctrl.exec)
        begin
            rd_data_reg <= slot_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg <= cmd;
            val_reg <= push_value;
        end
        if (ctrl.exec)
        begin
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IN_RESTRICTED;
            head_reg     <= '0;
            tail_reg     <= '0;
            empty_reg    <= 1'b1;
            pop_ok_reg   <= 1'b0;
            is_empty_reg <= 1'b1;
            is_full_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (ctrl.exec)
            begin
                head_reg     <= head_next;
                tail_reg     <= tail_next;
                empty_reg    <= empty_next;
                pop_ok_reg   <= pop_ok_next;
                is_empty_reg <= empty_next;
                is_full_reg  <= !empty_next && (tail_next == LAST_IDX);
            end
        end
    end

    assign status    = status_reg;
    assign pop_value = pop_ok_reg ? rd_data_reg : '0;
    assign is_empty  = is_empty_reg;
    assign is_full   = is_full_reg;

endmodule

// ===== rtl/core/restricted_deque_linear_array_unit.sv =====
// ----------------------------------------------------------------------------
// restricted_deque_linear_array_unit
// Input- or output-restricted deque in a linear, non-wrapping slot array.
// ----------------------------------------------------------------------------
// Sequencing: the sequencer runs capture, execute (memory access and index update)
//   and output; a new request is accepted only after the previous result has been
//   taken with m_tready, so requests are not overlapped.
// Reset: deque empty, head and tail at slot 0, mode input-restricted;
//   slot memory contents are not cleared.
module restricted_deque_linear_array_unit
    import rdq_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_wdata,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // cmd[2:0], push_value[34:3], zero pad
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // status[1:0], pop_value[33:2],
                                            // is_empty[34], is_full[35], zero pad
);

    rdq_ctrl_t           ctrl;
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   pop_value;
    logic                is_empty;
    logic                is_full;

    rdq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .ctrl     (ctrl)
    );

    rdq_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .cmd        (s_tdata[CMD_W-1:0]),
        .push_value (s_tdata[CMD_W+DATA_W-1:CMD_W]),
        .status     (status),
        .pop_value  (pop_value),
        .is_empty   (is_empty),
        .is_full    (is_full)
    );

    assign m_tdata = {4'd0, is_full, is_empty, pop_value, status};

endmodule
